### src/epa_pkg.sv
// Shared types and constants of the energy pulse accumulator.
`timescale 1ns / 1ps

package epa_pkg;

    // Channel layout: three groups of four, phases A, B, C then the phase total
    localparam int CHANNELS    = 12;
    localparam int CH_GROUP    = 4;
    localparam int CH_ACTIVE   = 0;
    localparam int CH_REACTIVE = 4;
    localparam int CH_APPARENT = 8;
    localparam int CH_TOTAL    = 3;

    // Field widths
    localparam int POWER_IN_W    = 32;
    localparam int APPARENT_IN_W = 31;
    localparam int POWER_W       = 34;
    localparam int HF_W          = 16;
    localparam int PULSE_W       = 16;
    localparam int CFG_INDEX_W   = 8;
    localparam int CFG_DATA_W    = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_HF   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REACTIVE_HF = 8'd1;
    localparam logic [HF_W-1:0]        HF_MIN          = 16'd10;

    // Registered stages ahead of the residue update (front register included)
    localparam int STAGES = 7;

    // Tick energy: divide by 36000 = 32 * 1125, the odd part by reciprocal
    localparam int TICK_PRE_SHIFT = 5;
    localparam int TICK_ODD       = 1125;
    localparam int TICK_SHIFT     = 40;
    localparam int TICK_IN_W      = 28;
    localparam int TICK_RECIP_W   = 30;
    localparam int ENERGY_W       = 18;
    localparam logic [63:0] TICK_RECIP =
        ((64'd1 << TICK_SHIFT) + 64'(TICK_ODD) - 64'd1) / 64'(TICK_ODD);

    // Pulse split of one tick's units: 1000000 = 64 * 15625
    localparam int UNIT_PRE_SHIFT = 6;
    localparam int UNIT_ODD       = 15625;
    localparam int UNIT_SHIFT     = 44;
    localparam int UNIT_IN_W      = 28;
    localparam int UNIT_RECIP_W   = 31;
    localparam logic [63:0] UNIT_RECIP =
        ((64'd1 << UNIT_SHIFT) + 64'(UNIT_ODD) - 64'd1) / 64'(UNIT_ODD);

    localparam int DELTA_W = 34;
    localparam int QUOT_W  = 15;
    localparam int REM_W   = 20;
    localparam int DQ_W    = 16;

    localparam logic [REM_W-1:0]   PULSE_UNITS = 20'd1000000;
    localparam logic [PULSE_W-1:0] MAX_PULSES  = 16'hFFFF;

    typedef logic signed [POWER_W-1:0] power_t;
    typedef logic [PULSE_W-1:0]        pulse_t;

    // Pipeline control shared by all lanes
    typedef struct packed {
        logic [STAGES-1:0] load;
        logic              commit;
        logic              run;
    } lane_ctl_t;

endpackage

### src/epa_in_if.sv
// Tick input channel: run flag and nine phase powers.
`timescale 1ns / 1ps

interface epa_in_if;
    import epa_pkg::*;

    logic                            valid;
    logic                            ready;
    logic                            run;
    logic signed [POWER_IN_W-1:0]    active_a_mw;
    logic signed [POWER_IN_W-1:0]    active_b_mw;
    logic signed [POWER_IN_W-1:0]    active_c_mw;
    logic signed [POWER_IN_W-1:0]    reactive_a_mvar;
    logic signed [POWER_IN_W-1:0]    reactive_b_mvar;
    logic signed [POWER_IN_W-1:0]    reactive_c_mvar;
    logic        [APPARENT_IN_W-1:0] apparent_a_mva;
    logic        [APPARENT_IN_W-1:0] apparent_b_mva;
    logic        [APPARENT_IN_W-1:0] apparent_c_mva;

    modport source (
        output valid, run, active_a_mw, active_b_mw, active_c_mw,
               reactive_a_mvar, reactive_b_mvar, reactive_c_mvar,
               apparent_a_mva, apparent_b_mva, apparent_c_mva,
        input  ready
    );

    modport sink (
        input  valid, run, active_a_mw, active_b_mw, active_c_mw,
               reactive_a_mvar, reactive_b_mvar, reactive_c_mvar,
               apparent_a_mva, apparent_b_mva, apparent_c_mva,
        output ready
    );
endinterface

### src/epa_out_if.sv
// Pulse result channel: twelve per-tick pulse counts.
`timescale 1ns / 1ps

interface epa_out_if;
    import epa_pkg::*;

    logic   valid;
    logic   ready;
    pulse_t active_a_pulses;
    pulse_t active_b_pulses;
    pulse_t active_c_pulses;
    pulse_t active_total_pulses;
    pulse_t reactive_a_pulses;
    pulse_t reactive_b_pulses;
    pulse_t reactive_c_pulses;
    pulse_t reactive_total_pulses;
    pulse_t apparent_a_pulses;
    pulse_t apparent_b_pulses;
    pulse_t apparent_c_pulses;
    pulse_t apparent_total_pulses;

    modport source (
        output valid, active_a_pulses, active_b_pulses, active_c_pulses,
               active_total_pulses, reactive_a_pulses, reactive_b_pulses,
               reactive_c_pulses, reactive_total_pulses, apparent_a_pulses,
               apparent_b_pulses, apparent_c_pulses, apparent_total_pulses,
        input  ready
    );

    modport sink (
        input  valid, active_a_pulses, active_b_pulses, active_c_pulses,
               active_total_pulses, reactive_a_pulses, reactive_b_pulses,
               reactive_c_pulses, reactive_total_pulses, apparent_a_pulses,
               apparent_b_pulses, apparent_c_pulses, apparent_total_pulses,
        output ready
    );
endinterface

### src/epa_cfg_if.sv
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface epa_cfg_if;
    import epa_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/epa_front.sv
// Front register: widens the phase powers and forms the three phase totals.
`timescale 1ns / 1ps

module epa_front (
    input  logic                                     clk,
    input  logic                                     load,
    input  logic signed [epa_pkg::POWER_IN_W-1:0]    active_a_mw,
    input  logic signed [epa_pkg::POWER_IN_W-1:0]    active_b_mw,
    input  logic signed [epa_pkg::POWER_IN_W-1:0]    active_c_mw,
    input  logic signed [epa_pkg::POWER_IN_W-1:0]    reactive_a_mvar,
    input  logic signed [epa_pkg::POWER_IN_W-1:0]    reactive_b_mvar,
    input  logic signed [epa_pkg::POWER_IN_W-1:0]    reactive_c_mvar,
    input  logic        [epa_pkg::APPARENT_IN_W-1:0] apparent_a_mva,
    input  logic        [epa_pkg::APPARENT_IN_W-1:0] apparent_b_mva,
    input  logic        [epa_pkg::APPARENT_IN_W-1:0] apparent_c_mva,
    output epa_pkg::power_t                          power [epa_pkg::CHANNELS]
);
    import epa_pkg::*;

    power_t power_next [CHANNELS];
    power_t power_reg  [CHANNELS];

    // Widen each phase, then add the three phases of each kind
    always_comb
    begin
        power_next[CH_ACTIVE + 0]   = POWER_W'(active_a_mw);
        power_next[CH_ACTIVE + 1]   = POWER_W'(active_b_mw);
        power_next[CH_ACTIVE + 2]   = POWER_W'(active_c_mw);
        power_next[CH_REACTIVE + 0] = POWER_W'(reactive_a_mvar);
        power_next[CH_REACTIVE + 1] = POWER_W'(reactive_b_mvar);
        power_next[CH_REACTIVE + 2] = POWER_W'(reactive_c_mvar);
        power_next[CH_APPARENT + 0] = power_t'({3'b000, apparent_a_mva});
        power_next[CH_APPARENT + 1] = power_t'({3'b000, apparent_b_mva});
        power_next[CH_APPARENT + 2] = power_t'({3'b000, apparent_c_mva});
        power_next[CH_ACTIVE + CH_TOTAL] = power_next[CH_ACTIVE + 0]
            + power_next[CH_ACTIVE + 1] + power_next[CH_ACTIVE + 2];
        power_next[CH_REACTIVE + CH_TOTAL] = power_next[CH_REACTIVE + 0]
            + power_next[CH_REACTIVE + 1] + power_next[CH_REACTIVE + 2];
        power_next[CH_APPARENT + CH_TOTAL] = power_next[CH_APPARENT + 0]
            + power_next[CH_APPARENT + 1] + power_next[CH_APPARENT + 2];
    end

    // Hold the item's powers while the stage is stalled
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            power_reg <= power_next;
        end
    end

    assign power = power_reg;

endmodule

### src/epa_lane.sv
// One energy channel: tick energy, pulse-unit scaling and the residue update.
`timescale 1ns / 1ps

module epa_lane #(
    parameter int RESIDUE_WIDTH = 48
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  epa_pkg::lane_ctl_t        ctl,
    input  logic [epa_pkg::HF_W-1:0]  hf,
    input  epa_pkg::power_t           power,
    output epa_pkg::pulse_t           count
);
    import epa_pkg::*;

    // Residue kept as whole pulses (hi) and units below one pulse (lo)
    localparam int HI_W = RESIDUE_WIDTH - 19;
    localparam logic [63:0] UNITS64 = 64'(PULSE_UNITS);
    localparam logic [63:0] HALF    = 64'd1 << (RESIDUE_WIDTH - 1);
    localparam logic [63:0] HMAX_U  = (HALF - 64'd1) / UNITS64;
    localparam logic [63:0] LMAX_U  = (HALF - 64'd1) % UNITS64;
    localparam logic [63:0] HMIN_U  = HALF / UNITS64 + 64'd1;
    localparam logic [63:0] LMIN_U  = UNITS64 - HALF % UNITS64;
    localparam logic signed [HI_W:0] HI_MAX = $signed(HMAX_U[HI_W:0]);
    localparam logic signed [HI_W:0] HI_MIN = -$signed(HMIN_U[HI_W:0]);
    localparam logic [REM_W-1:0]     LO_MAX = LMAX_U[REM_W-1:0];
    localparam logic [REM_W-1:0]     LO_MIN = LMIN_U[REM_W-1:0];
    localparam logic signed [HI_W:0] HI_ONE = (HI_W+1)'(1);
    localparam logic signed [HI_W:0] HI_CAP = $signed((HI_W+1)'(MAX_PULSES));

    logic [POWER_W-1:0]                   mag;
    logic [TICK_IN_W-1:0]                 mp_a_next;
    logic [TICK_IN_W+TICK_RECIP_W-1:0]    tick_prod;
    logic [UNIT_IN_W+UNIT_RECIP_W-1:0]    unit_prod;
    logic [DELTA_W-1:0]                   rem_full;
    logic signed [DQ_W-1:0]               quot_s;
    logic signed [DQ_W-1:0]               dq_next;
    logic [REM_W-1:0]                     dr_next;

    logic                      neg_a_reg;
    logic [TICK_IN_W-1:0]      mp_a_reg;
    logic                      neg_b_reg;
    logic [ENERGY_W-1:0]       energy_b_reg;
    logic                      neg_c_reg;
    logic [DELTA_W-1:0]        dmag_c_reg;
    logic                      neg_d_reg;
    logic [DELTA_W-1:0]        dmag_d_reg;
    logic [QUOT_W-1:0]         quot_d_reg;
    logic                      neg_e_reg;
    logic [QUOT_W-1:0]         quot_e_reg;
    logic [REM_W-1:0]          rem_e_reg;
    logic signed [DQ_W-1:0]    dq_f_reg;
    logic [REM_W-1:0]          dr_f_reg;

    logic signed [HI_W-1:0]    hi_reg;
    logic signed [HI_W-1:0]    hi_next;
    logic [REM_W-1:0]          lo_reg;
    logic [REM_W-1:0]          lo_next;

    logic [REM_W:0]            lo_sum;
    logic                      carry;
    logic [REM_W-1:0]          lo_wrap;
    logic [REM_W-1:0]          lo_sat;
    logic signed [HI_W:0]      hi_sum;
    logic signed [HI_W:0]      hi_sat;
    logic signed [HI_W:0]      hi_left;
    logic                      fire;
    pulse_t                    pulses_now;

    // Magnitude of the power, low five bits dropped for the 32 factor
    assign mag       = (power < 0) ? POWER_W'(-power) : POWER_W'(power);
    assign mp_a_next = mag[TICK_PRE_SHIFT +: TICK_IN_W];

    // Divide by 1125 through the reciprocal, exact over the input range
    assign tick_prod = (TICK_IN_W+TICK_RECIP_W)'(mp_a_reg)
                     * (TICK_IN_W+TICK_RECIP_W)'(TICK_RECIP[TICK_RECIP_W-1:0]);

    // Whole pulses in the scaled energy: divide by 15625 after the 64 factor
    assign unit_prod = (UNIT_IN_W+UNIT_RECIP_W)'(dmag_c_reg[UNIT_PRE_SHIFT +: UNIT_IN_W])
                     * (UNIT_IN_W+UNIT_RECIP_W)'(UNIT_RECIP[UNIT_RECIP_W-1:0]);

    // Units left over below one pulse
    assign rem_full = dmag_d_reg - DELTA_W'(quot_d_reg) * DELTA_W'(PULSE_UNITS);

    // Floor split of the signed energy: remainder always in [0, one pulse)
    assign quot_s = $signed({1'b0, quot_e_reg});
    always_comb
    begin
        if (!neg_e_reg)
        begin
            dq_next = quot_s;
            dr_next = rem_e_reg;
        end
        else if (rem_e_reg == '0)
        begin
            dq_next = -quot_s;
            dr_next = '0;
        end
        else
        begin
            dq_next = -quot_s - DQ_W'(1);
            dr_next = PULSE_UNITS - rem_e_reg;
        end
    end

    // Advance the arithmetic pipeline in step with the other lanes
    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            neg_a_reg <= (power < 0);
            mp_a_reg  <= mp_a_next;
        end
        if (ctl.load[2])
        begin
            neg_b_reg    <= neg_a_reg;
            energy_b_reg <= tick_prod[TICK_SHIFT +: ENERGY_W];
        end
        if (ctl.load[3])
        begin
            neg_c_reg  <= neg_b_reg;
            dmag_c_reg <= DELTA_W'(energy_b_reg) * DELTA_W'(hf);
        end
        if (ctl.load[4])
        begin
            neg_d_reg  <= neg_c_reg;
            dmag_d_reg <= dmag_c_reg;
            quot_d_reg <= unit_prod[UNIT_SHIFT +: QUOT_W];
        end
        if (ctl.load[5])
        begin
            neg_e_reg  <= neg_d_reg;
            quot_e_reg <= quot_d_reg;
            rem_e_reg  <= rem_full[REM_W-1:0];
        end
        if (ctl.load[6])
        begin
            dq_f_reg <= dq_next;
            dr_f_reg <= dr_next;
        end
    end

    // Add the energy, clamp to the residue range, then emit whole pulses
    always_comb
    begin
        lo_sum  = {1'b0, lo_reg} + {1'b0, dr_f_reg};
        carry   = (lo_sum >= {1'b0, PULSE_UNITS});
        lo_wrap = carry ? REM_W'(lo_sum - {1'b0, PULSE_UNITS}) : lo_sum[REM_W-1:0];
        hi_sum  = (HI_W+1)'(hi_reg) + (HI_W+1)'(dq_f_reg) + (HI_W+1)'(carry);

        if (hi_sum > HI_MAX || (hi_sum == HI_MAX && lo_wrap > LO_MAX))
        begin
            hi_sat = HI_MAX;
            lo_sat = LO_MAX;
        end
        else if (hi_sum < HI_MIN || (hi_sum == HI_MIN && lo_wrap < LO_MIN))
        begin
            hi_sat = HI_MIN;
            lo_sat = LO_MIN;
        end
        else
        begin
            hi_sat = hi_sum;
            lo_sat = lo_wrap;
        end

        // a residue of exactly one pulse stays put
        fire = (hi_sat > HI_ONE) || (hi_sat == HI_ONE && lo_sat != '0);
        if (!fire)
        begin
            pulses_now = '0;
        end
        else if (hi_sat > HI_CAP)
        begin
            pulses_now = MAX_PULSES;
        end
        else
        begin
            pulses_now = hi_sat[PULSE_W-1:0];
        end
        hi_left = hi_sat - (HI_W+1)'(pulses_now);

        if (!ctl.run)
        begin
            hi_next    = '0;
            lo_next    = '0;
            pulses_now = '0;
        end
        else
        begin
            hi_next = hi_left[HI_W-1:0];
            lo_next = lo_sat;
        end
    end

    // Update the residue once per item as it leaves the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else if (ctl.commit)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign count = pulses_now;

    a_lo_below_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg < PULSE_UNITS)
        else $error("residue units below one pulse out of range");

    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit && !ctl.run |=> hi_reg == '0 && lo_reg == '0)
        else $error("residue not cleared by a stopped tick");

endmodule

### src/epa_merge.sv
// Output register: gathers the twelve lane counts into one result item.
`timescale 1ns / 1ps

module epa_merge (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            commit,
    input  epa_pkg::pulse_t count [epa_pkg::CHANNELS],
    output logic            room,
    epa_out_if.source       pulses
);
    import epa_pkg::*;

    logic   out_valid_reg;
    logic   out_valid_next;
    pulse_t count_reg [CHANNELS];

    // Take a new item when the register is empty or being emptied
    assign room = !out_valid_reg || pulses.ready;

    always_comb
    begin
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pulses.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the counts until the item is taken
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            count_reg <= count;
        end
    end

    assign pulses.valid                 = out_valid_reg;
    assign pulses.active_a_pulses       = count_reg[CH_ACTIVE + 0];
    assign pulses.active_b_pulses       = count_reg[CH_ACTIVE + 1];
    assign pulses.active_c_pulses       = count_reg[CH_ACTIVE + 2];
    assign pulses.active_total_pulses   = count_reg[CH_ACTIVE + CH_TOTAL];
    assign pulses.reactive_a_pulses     = count_reg[CH_REACTIVE + 0];
    assign pulses.reactive_b_pulses     = count_reg[CH_REACTIVE + 1];
    assign pulses.reactive_c_pulses     = count_reg[CH_REACTIVE + 2];
    assign pulses.reactive_total_pulses = count_reg[CH_REACTIVE + CH_TOTAL];
    assign pulses.apparent_a_pulses     = count_reg[CH_APPARENT + 0];
    assign pulses.apparent_b_pulses     = count_reg[CH_APPARENT + 1];
    assign pulses.apparent_c_pulses     = count_reg[CH_APPARENT + 2];
    assign pulses.apparent_total_pulses = count_reg[CH_APPARENT + CH_TOTAL];

endmodule

### src/energy_pulse_accumulator.sv
// Twelve-channel energy pulse accumulator. Every item is one 100 ms metering tick; the block
// takes one item per clock cycle while the output side keeps taking. Twelve lanes, one per
// channel, work in parallel: each runs a six-stage pipeline (tick energy by reciprocal
// multiply, scaling by the pulse constant, split into whole pulses and leftover units) ahead
// of the residue update, the register loop that sets the one-item-per-cycle rate. Residues
// clear at reset with no clearing pass. Pulse constants below 10 act as 10; write them only
// while idle.
`timescale 1ns / 1ps

module energy_pulse_accumulator #(
    parameter int RESIDUE_WIDTH = 48
) (
    input logic        clk,
    input logic        rst_n,
    epa_in_if.sink     samples,
    epa_out_if.source  pulses,
    epa_cfg_if.sink    cfg
);
    import epa_pkg::*;

    logic [HF_W-1:0]   active_hf_reg;
    logic [HF_W-1:0]   reactive_hf_reg;
    logic [HF_W-1:0]   hf_active;
    logic [HF_W-1:0]   hf_reactive;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] run_reg;
    logic [STAGES:0]   rdy;
    logic              room;
    lane_ctl_t         lane_ctl;

    power_t            power [CHANNELS];
    pulse_t            count [CHANNELS];

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_hf_reg   <= HF_MIN;
            reactive_hf_reg <= HF_MIN;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_ACTIVE_HF:   active_hf_reg   <= cfg.data;
                CFG_REACTIVE_HF: reactive_hf_reg <= cfg.data;
                default:         ;
            endcase
        end
    end

    assign hf_active   = (active_hf_reg < HF_MIN) ? HF_MIN : active_hf_reg;
    assign hf_reactive = (reactive_hf_reg < HF_MIN) ? HF_MIN : reactive_hf_reg;

    // Ready chain: a stage moves on when it is empty or its successor moves
    always_comb
    begin
        rdy[STAGES] = room;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    always_comb
    begin
        valid_next[0] = rdy[0] ? samples.valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            valid_next[k] = rdy[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Carry the run flag alongside the item
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            run_reg[0] <= samples.run;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (rdy[k])
            begin
                run_reg[k] <= run_reg[k-1];
            end
        end
    end

    assign samples.ready   = rdy[0];
    assign lane_ctl.load   = rdy[STAGES-1:0];
    assign lane_ctl.commit = valid_reg[STAGES-1] && rdy[STAGES];
    assign lane_ctl.run    = run_reg[STAGES-1];

    epa_front u_front (
        .clk             (clk),
        .load            (rdy[0]),
        .active_a_mw     (samples.active_a_mw),
        .active_b_mw     (samples.active_b_mw),
        .active_c_mw     (samples.active_c_mw),
        .reactive_a_mvar (samples.reactive_a_mvar),
        .reactive_b_mvar (samples.reactive_b_mvar),
        .reactive_c_mvar (samples.reactive_c_mvar),
        .apparent_a_mva  (samples.apparent_a_mva),
        .apparent_b_mva  (samples.apparent_b_mva),
        .apparent_c_mva  (samples.apparent_c_mva),
        .power           (power)
    );

    // One lane per channel; the reactive group takes the reactive constant
    for (genvar ch = 0; ch < CHANNELS; ch++)
    begin : g_lane
        epa_lane #(
            .RESIDUE_WIDTH (RESIDUE_WIDTH)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (lane_ctl),
            .hf    ((ch >= CH_REACTIVE && ch < CH_REACTIVE + CH_GROUP)
                    ? hf_reactive : hf_active),
            .power (power[ch]),
            .count (count[ch])
        );
    end

    epa_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (lane_ctl.commit),
        .count  (count),
        .room   (room),
        .pulses (pulses)
    );

    a_accept_fills_front: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready |=> valid_reg[0])
        else $error("accepted item missing from the front stage");

    a_last_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[STAGES-1] && !rdy[STAGES] |=>
            valid_reg[STAGES-1] && $stable(run_reg[STAGES-1]))
        else $error("stalled item left the last stage");

    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        lane_ctl.commit |=> pulses.valid)
        else $error("committed item not presented at the output");

endmodule

### sim/tb_energy_pulse_accumulator.sv
// Testbench of the energy pulse accumulator: directed and random ticks against a residue predictor.
`timescale 1ns / 1ps

module tb_energy_pulse_accumulator;
    import epa_pkg::*;

    localparam int     RESIDUE_W       = 40;
    localparam longint TICK_DIV        = 36000;
    localparam longint UNITS_PER_PULSE = 1000000;
    localparam longint PULSE_CAP       = 65535;
    localparam longint RES_MAX         = (longint'(1) <<< (RESIDUE_W - 1)) - 1;
    localparam longint RES_MIN         = -RES_MAX - 1;
    localparam int     SAT_TICKS       = 150;
    localparam int     RANDOM_TICKS    = 250;

    // Index that selects no register; writes to it must leave both constants alone
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 8'hFF;

    // One metering tick, phase A at index 0
    typedef struct packed {
        logic                               run;
        logic [2:0][POWER_IN_W-1:0]    active;
        logic [2:0][POWER_IN_W-1:0]    reactive;
        logic [2:0][APPARENT_IN_W-1:0] apparent;
    } tick_t;

    // Pulse counts of one tick in channel order, active_a at index 0
    typedef pulse_t [CHANNELS-1:0] pulse_set_t;

    logic clk;
    logic rst_n;

    epa_in_if  samples_if ();
    epa_out_if pulses_if ();
    epa_cfg_if cfg_if ();

    energy_pulse_accumulator #(
        .RESIDUE_WIDTH (RESIDUE_W)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .pulses  (pulses_if),
        .cfg     (cfg_if)
    );

    // Predictor state: constant registers and per-channel residues
    logic [HF_W-1:0] active_hf;
    logic [HF_W-1:0] reactive_hf;
    longint          energy_left [CHANNELS];

    tick_t       tick_queue [$];
    tick_t       tick_on_bus;
    pulse_set_t  pulse_expect_q [$];
    int unsigned ticks_queued;
    int unsigned ticks_taken;
    bit          tick_taken_now;
    int          send_gap;
    int          stall_left;
    bit          idle_on;
    int          fail_count;

    string pulse_name [CHANNELS] = '{
        "active_a_pulses", "active_b_pulses", "active_c_pulses", "active_total_pulses",
        "reactive_a_pulses", "reactive_b_pulses", "reactive_c_pulses",
        "reactive_total_pulses", "apparent_a_pulses", "apparent_b_pulses",
        "apparent_c_pulses", "apparent_total_pulses"
    };

    // Advance the residues by one tick and return the pulses it emits
    function automatic pulse_set_t predict_pulses(input tick_t t);
        longint     pw [CHANNELS];
        longint     hf_act;
        longint     hf_rea;
        longint     hf;
        longint     acc;
        longint     q;
        pulse_set_t r;
        int         p;
        int         g;
        int         i;
        r = '0;
        hf_act = (active_hf < HF_MIN) ? longint'(HF_MIN) : longint'(active_hf);
        hf_rea = (reactive_hf < HF_MIN) ? longint'(HF_MIN) : longint'(reactive_hf);
        // Stopped: clear every residue, no pulses
        if (!t.run) begin
            for (i = 0; i < CHANNELS; i++)
                energy_left[i] = 0;
            return r;
        end
        for (p = 0; p < 3; p++) begin
            pw[CH_ACTIVE + p]   = longint'($signed(t.active[p]));
            pw[CH_REACTIVE + p] = longint'($signed(t.reactive[p]));
            pw[CH_APPARENT + p] = longint'({1'b0, t.apparent[p]});
        end
        for (g = 0; g < CHANNELS; g += CH_GROUP)
            pw[g + CH_TOTAL] = pw[g] + pw[g + 1] + pw[g + 2];
        for (i = 0; i < CHANNELS; i++) begin
            hf = (i >= CH_REACTIVE && i < CH_REACTIVE + CH_GROUP) ? hf_rea : hf_act;
            acc = energy_left[i] + (pw[i] / TICK_DIV) * hf;
            if (acc > RES_MAX)
                acc = RES_MAX;
            else if (acc < RES_MIN)
                acc = RES_MIN;
            // Emit whole pulses only strictly above one pulse worth of units
            if (acc > UNITS_PER_PULSE) begin
                q = acc / UNITS_PER_PULSE;
                if (q > PULSE_CAP)
                    q = PULSE_CAP;
                acc -= q * UNITS_PER_PULSE;
                r[i] = pulse_t'(q);
            end
            energy_left[i] = acc;
        end
        return r;
    endfunction

    // Build a tick with the same power on all three phases
    function automatic tick_t make_tick(input logic run, input logic [31:0] act,
                                        input logic [31:0] rea, input logic [30:0] app);
        tick_t t;
        t.run = run;
        t.active   = {3{act}};
        t.reactive = {3{rea}};
        t.apparent = {3{app}};
        return t;
    endfunction

    // Mix of full-range, extreme, divisor-edge, negative, near-zero and positive-biased powers
    function automatic logic [31:0] pick_power();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = $urandom();
            1:
            begin
                case ($urandom_range(0, 6))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'd0;
                    3: v = 32'd36000;
                    4: v = -32'sd36000;
                    5: v = 32'd35999;
                    default: v = -32'sd36001;
                endcase
            end
            2: v = 32'd0 - 32'($urandom_range(0, 32'h7FFF_FFFF));
            8: v = 32'($urandom_range(0, 200000)) - 32'd100000;
            9: v = 32'($urandom_range(0, 59000)) * 32'd36000
                   + 32'($urandom_range(0, 2)) - 32'd1;
            default: v = 32'($urandom_range(0, 32'h7FFF_FFFF));
        endcase
        return v;
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        int    p;
        logic [31:0] v;
        t.run = ($urandom_range(0, 39) != 0);
        for (p = 0; p < 3; p++) begin
            t.active[p]   = pick_power();
            t.reactive[p] = pick_power();
            v             = pick_power();
            t.apparent[p] = v[APPARENT_IN_W-1:0];
        end
        return t;
    endfunction

    function automatic void queue_tick(input tick_t t);
        tick_queue.push_back(t);
        ticks_queued++;
    endfunction

    // Hold until every queued tick is taken and every result item has come back
    task automatic wait_drained();
        while (ticks_taken != ticks_queued || pulse_expect_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        if (idx == CFG_ACTIVE_HF)
            active_hf = val;
        else if (idx == CFG_REACTIVE_HF)
            reactive_hf = val;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_random(input int n);
        @(posedge clk);
        repeat (n)
            queue_tick(random_tick());
        wait_drained();
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Timeout
    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Note each accepted tick and predict its result item
    always @(posedge clk)
    begin
        if (rst_n && samples_if.valid && samples_if.ready) begin
            pulse_expect_q.push_back(predict_pulses(tick_on_bus));
            ticks_taken++;
            tick_taken_now = 1'b1;
        end
    end

    // Tick driver: advance on acceptance, hold otherwise, idle in bursts
    always @(negedge clk)
    begin
        if (rst_n && (!samples_if.valid || tick_taken_now)) begin
            if (send_gap > 0) begin
                samples_if.valid <= 1'b0;
                send_gap--;
            end else if (tick_queue.size() > 0) begin
                tick_on_bus = tick_queue.pop_front();
                samples_if.run             <= tick_on_bus.run;
                samples_if.active_a_mw     <= tick_on_bus.active[0];
                samples_if.active_b_mw     <= tick_on_bus.active[1];
                samples_if.active_c_mw     <= tick_on_bus.active[2];
                samples_if.reactive_a_mvar <= tick_on_bus.reactive[0];
                samples_if.reactive_b_mvar <= tick_on_bus.reactive[1];
                samples_if.reactive_c_mvar <= tick_on_bus.reactive[2];
                samples_if.apparent_a_mva  <= tick_on_bus.apparent[0];
                samples_if.apparent_b_mva  <= tick_on_bus.apparent[1];
                samples_if.apparent_c_mva  <= tick_on_bus.apparent[2];
                samples_if.valid           <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 5);
            end else begin
                samples_if.valid <= 1'b0;
            end
        end
        tick_taken_now = 1'b0;
    end

    // Result side ready: stall in bursts
    always @(negedge clk)
    begin
        if (stall_left > 0) begin
            pulses_if.ready <= 1'b0;
            stall_left--;
        end else begin
            pulses_if.ready <= 1'b1;
            if (idle_on && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 5);
        end
    end

    // Compare each result item with the oldest prediction
    always @(posedge clk)
    begin
        pulse_set_t want;
        pulse_set_t got;
        int         i;
        if (rst_n && pulses_if.valid && pulses_if.ready) begin
            got = {pulses_if.apparent_total_pulses, pulses_if.apparent_c_pulses,
                   pulses_if.apparent_b_pulses, pulses_if.apparent_a_pulses,
                   pulses_if.reactive_total_pulses, pulses_if.reactive_c_pulses,
                   pulses_if.reactive_b_pulses, pulses_if.reactive_a_pulses,
                   pulses_if.active_total_pulses, pulses_if.active_c_pulses,
                   pulses_if.active_b_pulses, pulses_if.active_a_pulses};
            if (pulse_expect_q.size() == 0) begin
                $error("result item arrived with no tick outstanding");
                fail_count++;
            end else begin
                want = pulse_expect_q.pop_front();
                for (i = 0; i < CHANNELS; i++) begin
                    if (got[i] !== want[i]) begin
                        $error("%s: expected %0d, actual %0d", pulse_name[i], want[i], got[i]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        tick_t t;
        int    k;
        rst_n        = 1'b0;
        active_hf    = HF_MIN;
        reactive_hf  = HF_MIN;
        ticks_queued = 0;
        ticks_taken  = 0;
        send_gap     = 0;
        stall_left   = 0;
        idle_on      = 1'b1;
        fail_count   = 0;
        tick_taken_now = 1'b0;
        for (k = 0; k < CHANNELS; k++)
            energy_left[k] = 0;
        samples_if.valid = 1'b0;
        samples_if.run   = 1'b0;
        samples_if.active_a_mw     = '0;
        samples_if.active_b_mw     = '0;
        samples_if.active_c_mw     = '0;
        samples_if.reactive_a_mvar = '0;
        samples_if.reactive_b_mvar = '0;
        samples_if.reactive_c_mvar = '0;
        samples_if.apparent_a_mva  = '0;
        samples_if.apparent_b_mva  = '0;
        samples_if.apparent_c_mva  = '0;
        pulses_if.ready = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = '0;
        cfg_if.data     = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: stopped with full fields, extremes, truncation, exact threshold
        @(posedge clk);
        queue_tick(make_tick(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
        queue_tick(make_tick(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
        queue_tick(make_tick(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
        queue_tick(make_tick(1'b1, 32'h8000_0000, 32'h8000_0000, 31'd0));
        queue_tick(make_tick(1'b1, 32'd35999, -32'sd35999, 31'd35999));
        queue_tick(make_tick(1'b1, -32'sd36001, 32'd36001, 31'd36000));
        queue_tick(make_tick(1'b0, 32'd0, 32'd0, 31'd0));
        queue_tick(make_tick(1'b1, 32'd1_800_000_000, 32'd1_800_000_000, 31'd1_800_000_000));
        queue_tick(make_tick(1'b1, 32'd1_800_000_000, 32'd1_800_000_000, 31'd1_800_000_000));
        queue_tick(make_tick(1'b1, 32'd36000, 32'd36000, 31'd36000));
        wait_drained();

        // Constants below the floor, changed with residues held
        write_reg(CFG_ACTIVE_HF, 16'd0);
        write_reg(CFG_REACTIVE_HF, 16'd9);
        @(posedge clk);
        queue_tick(make_tick(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
        queue_tick(make_tick(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
        wait_drained();

        // Largest constants
        write_reg(CFG_ACTIVE_HF, 16'hFFFF);
        write_reg(CFG_REACTIVE_HF, 16'hFFFF);
        @(posedge clk);
        queue_tick(make_tick(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
        queue_tick(make_tick(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF));
        queue_tick(make_tick(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 31'd1));
        queue_tick(random_tick());
        wait_drained();

        // Spare index must not disturb either constant
        write_reg(CFG_SPARE, 16'hFFFF);
        write_reg(CFG_SPARE, 16'h0000);
        write_reg(CFG_ACTIVE_HF, 16'd10);
        @(posedge clk);
        queue_tick(make_tick(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
        queue_tick(random_tick());
        wait_drained();

        // Drive the active and reactive residues down to their negative limit, then recover
        write_reg(CFG_ACTIVE_HF, 16'hFFFF);
        @(posedge clk);
        queue_tick(make_tick(1'b0, 32'd0, 32'd0, 31'd0));
        t = make_tick(1'b1, 32'h8000_0000, 32'h8000_0000, 31'd0);
        for (k = 0; k < SAT_TICKS; k++) begin
            t.apparent = {3{31'($urandom_range(0, 32'h7FFF_FFFF))}};
            queue_tick(t);
        end
        repeat (3)
            queue_tick(make_tick(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
        queue_tick(make_tick(1'b0, 32'd0, 32'd0, 31'd0));
        wait_drained();

        // Random phases over several constant settings
        write_reg(CFG_ACTIVE_HF, 16'd10);
        write_reg(CFG_REACTIVE_HF, 16'd10);
        send_random(RANDOM_TICKS);

        write_reg(CFG_ACTIVE_HF, 16'hFFFF);
        write_reg(CFG_REACTIVE_HF, 16'hFFFF);
        send_random(RANDOM_TICKS);

        write_reg(CFG_ACTIVE_HF, 16'($urandom_range(0, 16'hFFFF)));
        write_reg(CFG_REACTIVE_HF, 16'($urandom_range(0, 16'hFFFF)));
        send_random(RANDOM_TICKS);

        write_reg(CFG_ACTIVE_HF, 16'($urandom_range(0, 9)));
        write_reg(CFG_REACTIVE_HF, 16'($urandom_range(10, 16'hFFFF)));
        send_random(RANDOM_TICKS);

        // Last phase at full rate
        write_reg(CFG_ACTIVE_HF, 16'($urandom_range(0, 16'hFFFF)));
        write_reg(CFG_REACTIVE_HF, 16'($urandom_range(0, 9)));
        @(posedge clk);
        idle_on = 1'b0;
        send_random(RANDOM_TICKS);

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
